// ===== design/crb_pkg.sv =====
// Shared constants, types and helper functions for the contrast blit block.
// Used by the interfaces, the raster, color and address units and the top level.
`timescale 1ns / 1ps
`default_nettype none

package crb_pkg;

  // Largest frame side in pixels; the raster counters are sized from it.
  localparam int MAX_SIDE = 4096;
  localparam int SIDE_W   = $clog2(MAX_SIDE);

  // Field widths of the channels and registers.
  localparam int PIX_W      = 32;
  localparam int OFFSET_W   = 32;
  localparam int PCT_W      = 9;
  localparam int SIZE_W     = 13;
  localparam int PITCH_W    = 16;
  localparam int OFFS_W     = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Contrast gain limits in percent.
  localparam logic [PCT_W-1:0] PCT_MIN = PCT_W'(20);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(300);

  // Division by 100 as a multiply by ceil(2^19 / 100) and a shift.
  // Exact for every magnitude up to 128 * 300.
  localparam int RECIP_W     = 13;
  localparam int RECIP_SHIFT = 19;
  localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

  // Channel constants.
  localparam logic [7:0] MID_GREY = 8'd128;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Register reset values.
  localparam logic [PCT_W-1:0]   PCT_RESET    = PCT_W'(100);
  localparam logic [SIZE_W-1:0]  WIDTH_RESET  = SIZE_W'(720);
  localparam logic [SIZE_W-1:0]  HEIGHT_RESET = SIZE_W'(1280);
  localparam logic [PITCH_W-1:0] PITCH_RESET  = PITCH_W'(2880);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST_PCT = 3'd0,
    REG_DEPTH_IS_16  = 3'd1,
    REG_FRAME_WIDTH  = 3'd2,
    REG_FRAME_HEIGHT = 3'd3,
    REG_ROW_PITCH    = 3'd4,
    REG_COL_OFFSET   = 3'd5,
    REG_ROW_OFFSET   = 3'd6
  } cfg_reg_t;

  // Position of one pixel in the frame and whether it closes a row or the frame.
  typedef struct packed {
    logic [SIDE_W-1:0] col;
    logic [SIDE_W-1:0] row;
    logic              last_col;
    logic              last_row;
  } raster_pos_t;

  // Clamp the contrast gain to its legal range.
  function automatic logic [PCT_W-1:0] pct_limit(input logic [PCT_W-1:0] pct);
    logic [PCT_W-1:0] r;
    if (pct < PCT_MIN) begin
      r = PCT_MIN;
    end else if (pct > PCT_MAX) begin
      r = PCT_MAX;
    end else begin
      r = pct;
    end
    return r;
  endfunction

  // Index of the last pixel along one side, with the side held to 1..MAX_SIDE.
  function automatic logic [SIDE_W-1:0] side_last(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] lim;
    if (v == '0) begin
      lim = (SIZE_W+1)'(1);
    end else if ({1'b0, v} > (SIZE_W+1)'(MAX_SIDE)) begin
      lim = (SIZE_W+1)'(MAX_SIDE);
    end else begin
      lim = {1'b0, v};
    end
    return SIDE_W'(lim - 1'b1);
  endfunction

endpackage

`default_nettype wire

// ===== design/crb_ifs.sv =====
// Valid/ready stream interfaces for source pixels and destination writes.
// Depends on crb_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface crb_in_if;
  logic                      valid;
  logic                      ready;
  logic [crb_pkg::PIX_W-1:0] src_pixel;

  modport source (output valid, output src_pixel, input ready);
  modport sink   (input valid, input src_pixel, output ready);
endinterface

interface crb_out_if;
  logic                         valid;
  logic                         ready;
  logic [crb_pkg::OFFSET_W-1:0] dest_offset;
  logic [crb_pkg::PIX_W-1:0]    dest_data;
  logic                         is_halfword;
  logic                         frame_end;

  modport source (output valid, output dest_offset, output dest_data,
                  output is_halfword, output frame_end, input ready);
  modport sink   (input valid, input dest_offset, input dest_data,
                  input is_halfword, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== design/crb_raster.sv =====
// Column and row counters that track the position of the next source pixel.
// Depends on crb_pkg for the counter width and the position struct.
`timescale 1ns / 1ps
`default_nettype none

module crb_raster (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic [crb_pkg::SIZE_W-1:0]   frame_width,
  input  logic [crb_pkg::SIZE_W-1:0]   frame_height,
  output crb_pkg::raster_pos_t         pos
);
  import crb_pkg::*;

  logic [SIDE_W-1:0] col_count;
  logic [SIDE_W-1:0] row_count;
  logic [SIDE_W-1:0] col_count_next;
  logic [SIDE_W-1:0] row_count_next;

  // A counter at or past the last index of a shrunken frame counts as last.
  assign pos.col      = col_count;
  assign pos.row      = row_count;
  assign pos.last_col = (col_count >= side_last(frame_width));
  assign pos.last_row = (row_count >= side_last(frame_height));

  // Advance one pixel per accepted item, wrapping at row and frame end.
  always_comb begin
    col_count_next = col_count;
    row_count_next = row_count;
    if (step) begin
      if (pos.last_col) begin
        col_count_next = '0;
        row_count_next = pos.last_row ? '0 : row_count + 1'b1;
      end else begin
        col_count_next = col_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/crb_color.sv =====
// Two-stage contrast stretch of R, G and B and packing to ARGB or RGB565.
// Depends on crb_pkg for the gain width, reciprocal and channel constants.
`timescale 1ns / 1ps
`default_nettype none

module crb_color (
  input  logic                        clk,
  input  logic                        en,
  input  logic [crb_pkg::PIX_W-1:0]   pixel,
  input  logic [crb_pkg::PCT_W-1:0]   pct,
  input  logic                        depth_is_16,
  output logic [crb_pkg::PIX_W-1:0]   data,
  output logic                        halfword
);
  import crb_pkg::*;

  localparam int MAG_W  = 16;
  localparam int PROD_W = MAG_W + RECIP_W;
  localparam int QUO_W  = 10;

  // Stage one: magnitude of (c - 128) * pct and its sign, per channel.
  logic [2:0][MAG_W-1:0] mag1;
  logic [2:0]            neg1;
  logic [7:0]            alpha1;
  logic                  depth1;
  logic [2:0][MAG_W-1:0] mag_comb;
  logic [2:0]            neg_comb;
  logic [2:0][7:0]       chan_comb;

  always_comb begin
    logic [7:0]       c;
    logic [7:0]       delta;
    logic [MAG_W:0]   prod;
    for (int k = 0; k < 3; k++) begin
      c     = pixel[8*k +: 8];
      // Distance from mid grey; below mid grey the result is negative.
      delta = c[7] ? {1'b0, c[6:0]} : MID_GREY - c;
      prod  = delta * pct;
      mag_comb[k] = prod[MAG_W-1:0];
      neg_comb[k] = ~c[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1   <= mag_comb;
      neg1   <= neg_comb;
      alpha1 <= pixel[PIX_W-1 -: 8];
      depth1 <= depth_is_16;
    end
  end

  // Stage two: divide by 100 with truncation toward zero, re-center and clamp.
  always_comb begin
    logic [PROD_W-1:0] scaled;
    logic [QUO_W-1:0]  quo;
    for (int k = 0; k < 3; k++) begin
      scaled = PROD_W'(mag1[k]) * PROD_W'(RECIP_100);
      quo    = scaled[RECIP_SHIFT +: QUO_W];
      if (quo >= QUO_W'(MID_GREY)) begin
        chan_comb[k] = neg1[k] ? 8'd0 : CHAN_MAX;
      end else if (neg1[k]) begin
        chan_comb[k] = MID_GREY - quo[7:0];
      end else begin
        chan_comb[k] = MID_GREY + quo[7:0];
      end
    end
  end

  // Pack the result; channel 2 is red, 1 green, 0 blue.
  always_ff @(posedge clk) begin
    if (en) begin
      if (depth1) begin
        data <= {16'd0, chan_comb[2][7:3], chan_comb[1][7:2], chan_comb[0][7:3]};
      end else begin
        data <= {alpha1, chan_comb[2], chan_comb[1], chan_comb[0]};
      end
      halfword <= depth1;
    end
  end

endmodule

`default_nettype wire

// ===== design/crb_addr.sv =====
// Two-stage destination byte offset: (row + row_offset) * pitch + (col + col_offset) * bpp.
// Depends on crb_pkg for the position struct and register widths.
`timescale 1ns / 1ps
`default_nettype none

module crb_addr (
  input  logic                          clk,
  input  logic                          en,
  input  crb_pkg::raster_pos_t          pos,
  input  logic                          depth_is_16,
  input  logic [crb_pkg::PITCH_W-1:0]   row_pitch_bytes,
  input  logic [crb_pkg::OFFS_W-1:0]    col_offset,
  input  logic [crb_pkg::OFFS_W-1:0]    row_offset,
  output logic [crb_pkg::OFFSET_W-1:0]  offset,
  output logic                          frame_end
);
  import crb_pkg::*;

  localparam int SUM_W  = ((SIDE_W > OFFS_W) ? SIDE_W : OFFS_W) + 1;
  localparam int ROWB_W = SUM_W + PITCH_W;
  localparam int COLB_W = SUM_W + 2;

  logic [SUM_W-1:0]  row_sum;
  logic [SUM_W-1:0]  col_sum;
  logic [ROWB_W-1:0] row_bytes1;
  logic [COLB_W-1:0] col_bytes1;
  logic              frame_end1;

  assign row_sum = SUM_W'(pos.row) + SUM_W'(row_offset);
  assign col_sum = SUM_W'(pos.col) + SUM_W'(col_offset);

  // Stage one: the row product, and the column scaled by 2 or 4 bytes.
  always_ff @(posedge clk) begin
    if (en) begin
      row_bytes1 <= ROWB_W'(row_sum) * ROWB_W'(row_pitch_bytes);
      col_bytes1 <= depth_is_16 ? {1'b0, col_sum, 1'b0} : {col_sum, 2'b00};
      frame_end1 <= pos.last_col & pos.last_row;
    end
  end

  // Stage two: sum modulo 2^32.
  always_ff @(posedge clk) begin
    if (en) begin
      offset    <= OFFSET_W'(row_bytes1) + OFFSET_W'(col_bytes1);
      frame_end <= frame_end1;
    end
  end

endmodule

`default_nettype wire

// ===== design/contrast_rgb565_blit_top.sv =====
// Top level of the contrast stretch blit: configuration, pipeline control.
// Depends on crb_pkg, crb_ifs, crb_raster, crb_color and crb_addr.
//
//   Port       Role    Carries
//   src        sink    one ARGB source pixel per item, raster order
//   dst        source  byte offset, pixel data, write size, frame end mark
//   cfg_*      write   register index and data, taken when cfg_we is high
//
// One item per clock while the output is not stalled; a result is presented once it
// has passed the input register, the product register and the output register.
// The three stages advance together whenever the output register is empty or
// being taken, so src.ready follows dst.ready while a result waits.
// Synchronous reset clears the stage valid bits, the raster counters and the
// configuration registers to their defaults; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module contrast_rgb565_blit_top (
  input  logic                            clk,
  input  logic                            rst,
  crb_in_if.sink                          src,
  crb_out_if.source                       dst,
  input  logic                            cfg_we,
  input  logic [crb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [crb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import crb_pkg::*;

  // Configuration registers.
  logic [PCT_W-1:0]   contrast_pct;
  logic               depth_is_16;
  logic [SIZE_W-1:0]  frame_width;
  logic [SIZE_W-1:0]  frame_height;
  logic [PITCH_W-1:0] row_pitch_bytes;
  logic [OFFS_W-1:0]  col_offset;
  logic [OFFS_W-1:0]  row_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      contrast_pct    <= PCT_RESET;
      depth_is_16     <= 1'b0;
      frame_width     <= WIDTH_RESET;
      frame_height    <= HEIGHT_RESET;
      row_pitch_bytes <= PITCH_RESET;
      col_offset      <= '0;
      row_offset      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CONTRAST_PCT: contrast_pct    <= cfg_data[PCT_W-1:0];
        REG_DEPTH_IS_16:  depth_is_16     <= cfg_data[0];
        REG_FRAME_WIDTH:  frame_width     <= cfg_data[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height    <= cfg_data[SIZE_W-1:0];
        REG_ROW_PITCH:    row_pitch_bytes <= cfg_data[PITCH_W-1:0];
        REG_COL_OFFSET:   col_offset      <= cfg_data[OFFS_W-1:0];
        REG_ROW_OFFSET:   row_offset      <= cfg_data[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: all stages move together when the output can accept.
  logic        advance;
  logic        accept;
  logic [2:0]  stage_valid;

  assign advance   = ~stage_valid[2] | dst.ready;
  assign accept    = src.valid & advance;
  assign src.ready = advance;
  assign dst.valid = stage_valid[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else if (advance) begin
      stage_valid <= {stage_valid[1:0], src.valid};
    end
  end

  // Raster position of the next item.
  raster_pos_t pos;

  crb_raster u_raster (
    .clk          (clk),
    .rst          (rst),
    .step         (accept),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pos          (pos)
  );

  // Input register: pixel and its position.
  logic [PIX_W-1:0] pixel0;
  raster_pos_t      pos0;

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel0 <= src.src_pixel;
      pos0   <= pos;
    end
  end

  // Color and address paths.
  logic [PCT_W-1:0] pct_eff;

  assign pct_eff = pct_limit(contrast_pct);

  crb_color u_color (
    .clk         (clk),
    .en          (advance),
    .pixel       (pixel0),
    .pct         (pct_eff),
    .depth_is_16 (depth_is_16),
    .data        (dst.dest_data),
    .halfword    (dst.is_halfword)
  );

  crb_addr u_addr (
    .clk             (clk),
    .en              (advance),
    .pos             (pos0),
    .depth_is_16     (depth_is_16),
    .row_pitch_bytes (row_pitch_bytes),
    .col_offset      (col_offset),
    .row_offset      (row_offset),
    .offset          (dst.dest_offset),
    .frame_end       (dst.frame_end)
  );

`ifndef SYNTHESIS
  // The last pixel of a frame sends both counters back to the origin.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (accept && pos.last_col && pos.last_row) |=> (pos.col == '0 && pos.row == '0))
    else $error("raster counters did not wrap at frame end");

  // Within a row, each item moves one column on and leaves the row alone.
  a_col_step: assert property (@(posedge clk) disable iff (rst)
    (accept && !pos.last_col) |=>
      (pos.col == $past(pos.col) + 1'b1 && $stable(pos.row)))
    else $error("column counter did not step by one");

  // A packed RGB565 result leaves the upper half of the data word clear.
  a_half_upper: assert property (@(posedge clk) disable iff (rst)
    (dst.valid && dst.is_halfword) |-> (dst.dest_data[PIX_W-1:PIX_W/2] == '0))
    else $error("upper half set on a halfword write");
`endif

endmodule

`default_nettype wire
